@@ rtl/machine_set_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Machine set allocator assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// The including scope must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MACHINE_SET_ALLOCATOR_MACROS_SVH
`define MACHINE_SET_ALLOCATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MSA_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define MSA_NEVER(label, cond, msg) \
    `MSA_CHECK(label, !(cond), msg)

`endif

@@ rtl/msa_pkg.sv @@
// ----------------------------------------------------------------------------
// Machine set allocator package
// Shared widths, operation codes, controller states and channel structs.
// ----------------------------------------------------------------------------
package msa_pkg;

    // Field widths fixed by the interface.
    localparam int MSA_ID_W  = 6;
    localparam int MSA_CNT_W = 7;

    // Default number of machines and the widest ID span the fields can name.
    localparam int MSA_MACHINE_COUNT = 64;
    localparam int MSA_MAX_SPAN      = 64;

    // Operation codes.
    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_TAKE     = 3'd2;
    localparam logic [2:0] OP_BIGGEST  = 3'd3;
    localparam logic [2:0] OP_CONTAINS = 3'd4;
    localparam logic [2:0] OP_INDEX    = 3'd5;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_REPLY
    } msa_state_t;

    // One request.
    typedef struct packed {
        logic [2:0]           operation;
        logic [MSA_ID_W-1:0]  range_low;
        logic [MSA_ID_W-1:0]  range_high;
        logic [MSA_CNT_W-1:0] count;
    } msa_req_t;

    // One result.
    typedef struct packed {
        logic [MSA_ID_W-1:0]  interval_low;
        logic [MSA_ID_W-1:0]  interval_high;
        logic                 found;
        logic                 is_member;
        logic [MSA_ID_W-1:0]  element_id;
        logic [MSA_CNT_W-1:0] set_size;
        logic                 error;
        logic                 last;
    } msa_rsp_t;

    // Controls from the sequencer to the bitmap ring.
    typedef struct packed {
        logic advance;
        logic new_bit;
    } msa_ring_ctl_t;

    // Status from the bitmap ring to the sequencer.
    typedef struct packed {
        logic bit_cur;
        logic bit_next;
        logic at_last;
    } msa_ring_stat_t;

endpackage

@@ rtl/msa_ring.sv @@
// ----------------------------------------------------------------------------
// Machine set allocator bitmap ring
// Membership bitmap held as a circular shift register that rotates one bit
// per advance, with a counter tracking the ID of the bit at the output tap.
// ----------------------------------------------------------------------------
module msa_ring
    import msa_pkg::*;
#(
    parameter int ID_SPAN = MSA_MAX_SPAN
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  msa_ring_ctl_t              ctl,
    output msa_ring_stat_t             stat,
    output logic [$clog2(ID_SPAN)-1:0] pos
);

    localparam int POS_W = $clog2(ID_SPAN);

    logic [ID_SPAN-1:0] bitmap_reg;
    logic [ID_SPAN-1:0] bitmap_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               at_last;

    // The tap shows the current ID and looks one ID ahead.
    assign at_last       = (pos_reg == POS_W'(ID_SPAN - 1));
    assign stat.bit_cur  = bitmap_reg[0];
    assign stat.bit_next = bitmap_reg[1];
    assign stat.at_last  = at_last;
    assign pos           = pos_reg;

    // Rotation: the tapped bit leaves, its (possibly rewritten) value re-enters at the top.
    always_comb
    begin
        bitmap_next = bitmap_reg;
        pos_next    = pos_reg;
        if (ctl.advance)
        begin
            bitmap_next = {ctl.new_bit, bitmap_reg[ID_SPAN-1:1]};
            pos_next    = at_last ? '0 : pos_reg + 1'b1;
        end
    end

    // The set is empty after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            bitmap_reg <= bitmap_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

@@ rtl/machine_set_allocator.sv @@
// ----------------------------------------------------------------------------
// Machine set allocator
// Keeps a set of machine IDs as a bitmap and serves insert, remove,
// take-first, biggest-interval, contains and index requests.
// ----------------------------------------------------------------------------
// Timing: the bitmap sits in a ring that rotates one ID per cycle during each
// turn, held only while a take-first interval waits for the output register,
// so every request is handled bit-serially. Each request first makes one full
// turn of the ring (ID_SPAN IDs, ID_SPAN = min(MACHINE_COUNT, 64)) that applies
// any insert or remove and counts the members. Take-first, biggest-interval and
// index requests that are not settled by the count make a second full turn.
// Insert, remove, contains and requests settled by the count present their
// result once the first turn ends, biggest-interval and index once the second
// turn ends. Take-first presents its intervals during the second turn. A final
// result waits while the consumer holds off an earlier result that still
// blocks the output register. A new request is taken once the final result
// has been loaded (after the second turn for take-first), even while the last
// result of the previous request still waits in the output register.
module machine_set_allocator
    import msa_pkg::*;
#(
    parameter int MACHINE_COUNT = MSA_MACHINE_COUNT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  msa_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output msa_rsp_t rsp
);

    localparam int ID_SPAN = (MACHINE_COUNT < MSA_MAX_SPAN) ? MACHINE_COUNT : MSA_MAX_SPAN;
    localparam int POS_W   = $clog2(ID_SPAN);

    msa_state_t           state_reg, state_next;
    msa_req_t             req_reg, req_next;
    logic [MSA_CNT_W-1:0] size_reg, size_next;
    logic                 member_reg, member_next;
    logic [MSA_CNT_W-1:0] tally_reg, tally_next;
    logic                 run_active_reg, run_active_next;
    logic [MSA_ID_W-1:0]  run_start_reg, run_start_next;
    logic [MSA_CNT_W-1:0] run_len_reg, run_len_next;
    logic [MSA_ID_W-1:0]  best_lo_reg, best_lo_next;
    logic [MSA_ID_W-1:0]  best_hi_reg, best_hi_next;
    logic [MSA_CNT_W-1:0] best_len_reg, best_len_next;
    logic                 got_reg, got_next;
    logic [MSA_ID_W-1:0]  elem_reg, elem_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    msa_rsp_t             rsp_reg;

    msa_ring_ctl_t        ring_ctl;
    msa_ring_stat_t       ring_stat;
    logic [POS_W-1:0]     pos;

    logic [MSA_ID_W-1:0]  id_cur;
    logic                 slot_free;
    logic                 in_range;
    logic [MSA_CNT_W-1:0] size_fin;
    logic [MSA_CNT_W-1:0] tally_inc;
    logic [MSA_CNT_W-1:0] cur_len;
    logic [MSA_ID_W-1:0]  cur_start;
    logic                 run_end;
    logic                 rsp_load;
    msa_rsp_t             rsp_load_data;

    // Bitmap ring.
    msa_ring #(
        .ID_SPAN (ID_SPAN)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .stat  (ring_stat),
        .pos   (pos)
    );

    // Shared per-bit quantities.
    assign id_cur    = MSA_ID_W'(pos);
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign in_range  = (req_reg.range_low <= req_reg.range_high)
                    && (req_reg.range_low <= id_cur)
                    && (id_cur <= req_reg.range_high);
    assign tally_inc = tally_reg + 1'b1;
    assign cur_len   = run_active_reg ? run_len_reg + 1'b1 : MSA_CNT_W'(1);
    assign cur_start = run_active_reg ? run_start_reg : id_cur;
    assign run_end   = !ring_stat.bit_next || ring_stat.at_last;

    // Sequencer: next state, datapath updates and result composition.
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        size_next        = size_reg;
        member_next      = member_reg;
        tally_next       = tally_reg;
        run_active_next  = run_active_reg;
        run_start_next   = run_start_reg;
        run_len_next     = run_len_reg;
        best_lo_next     = best_lo_reg;
        best_hi_next     = best_hi_reg;
        best_len_next    = best_len_reg;
        got_next         = got_reg;
        elem_next        = elem_reg;
        ring_ctl.advance = 1'b0;
        ring_ctl.new_bit = ring_stat.bit_cur;
        size_fin         = size_reg;
        rsp_load         = 1'b0;
        rsp_load_data    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    size_next   = '0;
                    member_next = 1'b0;
                    state_next  = ST_UPDATE;
                end
            end

            // First turn: apply insert or remove, count members, test one ID.
            ST_UPDATE:
            begin
                ring_ctl.advance = 1'b1;
                if ((req_reg.operation inside {OP_INSERT, OP_REMOVE}) && in_range)
                begin
                    ring_ctl.new_bit = (req_reg.operation == OP_INSERT);
                end
                size_fin  = size_reg + MSA_CNT_W'(ring_ctl.new_bit);
                size_next = size_fin;
                if (id_cur == req_reg.range_low)
                begin
                    member_next = ring_stat.bit_cur;
                end
                tally_next      = '0;
                run_active_next = 1'b0;
                run_len_next    = '0;
                best_len_next   = '0;
                best_lo_next    = '0;
                best_hi_next    = '0;
                got_next        = 1'b0;
                if (ring_stat.at_last)
                begin
                    state_next = ST_REPLY;
                    case (req_reg.operation)
                        OP_TAKE:
                        begin
                            if ((req_reg.count <= size_fin) && (req_reg.count != '0))
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_BIGGEST:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_INDEX:
                        begin
                            if (req_reg.count < size_fin)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            // Second turn: walk the members in ascending order.
            ST_SCAN:
            begin
                ring_ctl.advance = 1'b1;
                case (req_reg.operation)
                    OP_TAKE:
                    begin
                        if (ring_stat.bit_cur && (tally_reg < req_reg.count))
                        begin
                            // A run closes at a gap, at the top ID, or when enough are taken.
                            if (run_end || (tally_inc == req_reg.count))
                            begin
                                if (slot_free)
                                begin
                                    rsp_load                    = 1'b1;
                                    rsp_load_data.interval_low  = cur_start;
                                    rsp_load_data.interval_high = id_cur;
                                    rsp_load_data.found         = 1'b1;
                                    rsp_load_data.set_size      = size_reg;
                                    rsp_load_data.last          = (tally_inc == req_reg.count);
                                    run_active_next             = 1'b0;
                                    tally_next                  = tally_inc;
                                end
                                else
                                begin
                                    ring_ctl.advance = 1'b0;
                                end
                            end
                            else
                            begin
                                run_active_next = 1'b1;
                                run_start_next  = cur_start;
                                tally_next      = tally_inc;
                            end
                        end
                    end
                    OP_BIGGEST:
                    begin
                        if (ring_stat.bit_cur)
                        begin
                            run_active_next = !run_end;
                            run_start_next  = cur_start;
                            run_len_next    = cur_len;
                            // Only a strictly longer run replaces the best, so the first one wins.
                            if (run_end && (cur_len > best_len_reg))
                            begin
                                best_len_next = cur_len;
                                best_lo_next  = cur_start;
                                best_hi_next  = id_cur;
                            end
                        end
                    end
                    default:
                    begin
                        // Index: count members until the wanted position.
                        if (ring_stat.bit_cur)
                        begin
                            if ((tally_reg == req_reg.count) && !got_reg)
                            begin
                                got_next  = 1'b1;
                                elem_next = id_cur;
                            end
                            tally_next = tally_inc;
                        end
                    end
                endcase
                if (ring_ctl.advance && ring_stat.at_last)
                begin
                    state_next = (req_reg.operation == OP_TAKE) ? ST_IDLE : ST_REPLY;
                end
            end

            // Single final result.
            ST_REPLY:
            begin
                rsp_load_data.set_size = size_reg;
                rsp_load_data.last     = 1'b1;
                case (req_reg.operation)
                    OP_TAKE:
                    begin
                        rsp_load_data.error = (req_reg.count > size_reg);
                    end
                    OP_BIGGEST:
                    begin
                        rsp_load_data.found         = (best_len_reg != '0);
                        rsp_load_data.interval_low  = best_lo_reg;
                        rsp_load_data.interval_high = best_hi_reg;
                    end
                    OP_CONTAINS:
                    begin
                        rsp_load_data.is_member = member_reg;
                    end
                    OP_INDEX:
                    begin
                        rsp_load_data.error = (req_reg.count >= size_reg);
                        if (req_reg.count < size_reg)
                        begin
                            rsp_load_data.found      = 1'b1;
                            rsp_load_data.element_id = elem_reg;
                        end
                    end
                    default:
                    begin
                        rsp_load_data.error = 1'b0;
                    end
                endcase
                if (slot_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        size_reg       <= size_next;
        member_reg     <= member_next;
        tally_reg      <= tally_next;
        run_active_reg <= run_active_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        best_lo_reg    <= best_lo_next;
        best_hi_reg    <= best_hi_next;
        best_len_reg   <= best_len_next;
        got_reg        <= got_next;
        elem_reg       <= elem_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_load_data;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/msa_checker.sv @@
// ----------------------------------------------------------------------------
// Machine set allocator checker
// Port-level assertions on the allocator, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "machine_set_allocator_macros.svh"

module msa_checker
    import msa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input msa_rsp_t rsp
);

    logic rsp_stall;

    // A result is offered but the consumer holds it off.
    assign rsp_stall = rsp_valid && !rsp_ready;

    // A result held off by the consumer stays unchanged.
    `MSA_CHECK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp), "result changed while stalled")

    // The block works on one request at a time.
    `MSA_CHECK(a_busy_after_req, req_valid && req_ready |=> !req_ready, "request taken while busy")

    // A result is never both found and in error.
    `MSA_NEVER(a_err_found, rsp_valid && rsp.error && rsp.found, "error and found both set")

    // Only a take-first interval can be followed by more results.
    `MSA_CHECK(a_partial_take, rsp_valid && !rsp.last |-> rsp.found && !rsp.error, "bad partial result")

    // The set never holds more than the whole ID range.
    `MSA_NEVER(a_size_range, rsp_valid && (rsp.set_size > 7'd64), "set size out of range")

endmodule

bind machine_set_allocator msa_checker u_msa_checker (.*);

@@ bench/set_reply_checker.sv @@
// ----------------------------------------------------------------------------
// Machine set allocator reply checker
// Watches both channels of the allocator and keeps its own copy of the
// member bitmap. Every accepted request produces the replies the block should
// give. Every accepted reply is compared, field by field, with the oldest one
// still waiting. Mismatches and stray replies are counted for the bench top.
// ----------------------------------------------------------------------------
module set_reply_checker
    import msa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  msa_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  msa_rsp_t rsp,
    output int       mismatch_total,
    output int       outstanding,
    output int       requests_checked,
    output int       results_checked,
    output int       longest_reply
);

    // Shadow of the member bitmap and the replies still owed by the block.
    logic [MSA_MAX_SPAN-1:0] members = '0;
    msa_rsp_t                expected_results[$];
    int                      mismatches    = 0;
    int                      requests_seen = 0;
    int                      results_seen  = 0;
    int                      widest_reply  = 0;

    // Append one reply to the back of the owed list.
    task automatic owe_reply(input msa_rsp_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    // Apply one request to the shadow bitmap and queue the replies it causes.
    task automatic predict_results(input msa_req_t r);
        msa_rsp_t reply;
        int       size;
        int       idx;
        int       start;
        int       taken;
        int       best_lo;
        int       best_len;
        int       seen;
        int       queued;
        queued = expected_results.size();
        reply  = '0;
        if ((r.operation == OP_INSERT || r.operation == OP_REMOVE) &&
            r.range_low <= r.range_high)
        begin
            for (idx = r.range_low; idx <= r.range_high; idx++)
                members[idx] = (r.operation == OP_INSERT);
        end
        size = $countones(members);
        reply.set_size = MSA_CNT_W'(size);
        reply.last     = 1'b1;

        case (r.operation)
            OP_TAKE:
            begin
                if (r.count > size)
                begin
                    reply.error = 1'b1;
                    owe_reply(reply);
                end
                else if (r.count == 0)
                begin
                    owe_reply(reply);
                end
                else
                begin
                    // Walk the runs from the bottom, cutting the final one
                    // short once enough members have been handed out.
                    taken = 0;
                    idx   = 0;
                    while (idx < MSA_MAX_SPAN && taken < r.count)
                    begin
                        if (members[idx])
                        begin
                            start = idx;
                            while (idx + 1 < MSA_MAX_SPAN && members[idx + 1] &&
                                   taken + (idx - start + 1) < r.count)
                                idx++;
                            taken += idx - start + 1;
                            reply.interval_low  = MSA_ID_W'(start);
                            reply.interval_high = MSA_ID_W'(idx);
                            reply.found         = 1'b1;
                            reply.last          = (taken == r.count);
                            owe_reply(reply);
                        end
                        idx++;
                    end
                end
            end
            OP_BIGGEST:
            begin
                // The first run wins a tie, so only a strictly longer one
                // replaces it.
                best_lo  = 0;
                best_len = 0;
                idx      = 0;
                while (idx < MSA_MAX_SPAN)
                begin
                    if (members[idx])
                    begin
                        start = idx;
                        while (idx + 1 < MSA_MAX_SPAN && members[idx + 1])
                            idx++;
                        if (idx - start + 1 > best_len)
                        begin
                            best_len = idx - start + 1;
                            best_lo  = start;
                        end
                    end
                    idx++;
                end
                if (best_len != 0)
                begin
                    reply.interval_low  = MSA_ID_W'(best_lo);
                    reply.interval_high = MSA_ID_W'(best_lo + best_len - 1);
                    reply.found         = 1'b1;
                end
                owe_reply(reply);
            end
            OP_CONTAINS:
            begin
                reply.is_member = members[r.range_low];
                owe_reply(reply);
            end
            OP_INDEX:
            begin
                if (r.count >= size)
                begin
                    reply.error = 1'b1;
                end
                else
                begin
                    seen = 0;
                    for (idx = 0; idx < MSA_MAX_SPAN; idx++)
                    begin
                        if (members[idx])
                        begin
                            if (seen == r.count)
                            begin
                                reply.found      = 1'b1;
                                reply.element_id = MSA_ID_W'(idx);
                            end
                            seen++;
                        end
                    end
                end
                owe_reply(reply);
            end
            default:
            begin
                owe_reply(reply);
            end
        endcase

        requests_seen++;
        if (expected_results.size() - queued > widest_reply)
            widest_reply = expected_results.size() - queued;
    endtask

    // Report one field that differs from its expected value.
    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare one accepted reply with the oldest one still owed.
    task automatic compare_result(input msa_rsp_t got);
        msa_rsp_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            $error("Reply accepted while no reply was owed.");
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("interval_low",  7'(want.interval_low),  7'(got.interval_low));
            check_field("interval_high", 7'(want.interval_high), 7'(got.interval_high));
            check_field("found",         7'(want.found),         7'(got.found));
            check_field("is_member",     7'(want.is_member),     7'(got.is_member));
            check_field("element_id",    7'(want.element_id),    7'(got.element_id));
            check_field("set_size",      want.set_size,          got.set_size);
            check_field("error",         7'(want.error),         7'(got.error));
            check_field("last",          7'(want.last),          7'(got.last));
        end
    endtask

    // Replies are compared before a request in the same cycle is predicted,
    // so a new request never disturbs the replies already owed.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            members = '0;
            expected_results.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                compare_result(rsp);
            if (req_valid && req_ready)
                predict_results(req);
        end
        mismatch_total   <= mismatches;
        outstanding      <= expected_results.size();
        requests_checked <= requests_seen;
        results_checked  <= results_seen;
        longest_reply    <= widest_reply;
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Machine set allocator testbench
// Drives the allocator with a short directed sequence covering the empty and
// full set, inverted ranges, overlong take-first and index requests and the
// unused operation codes, followed by random requests with bursty traffic and
// an irregular consumer. A separate checker predicts and compares the replies.
// ----------------------------------------------------------------------------
module testbench;
    import msa_pkg::*;

    // Operation codes the block does not define.
    localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

    localparam int DIRECTED_REQUESTS = 24;
    localparam int RANDOM_REQUESTS   = 246;
    localparam int QUIET_LIMIT       = 4000;
    localparam int DRAIN_CYCLES      = 2 * MSA_MAX_SPAN + 16;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    msa_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    msa_rsp_t rsp;

    int mismatch_total;
    int outstanding;
    int requests_checked;
    int results_checked;
    int longest_reply;

    int burst_left   = 0;
    int issued       = 0;
    int quiet_cycles = 0;
    int open_run     = 0;
    int stall_run    = 0;

    machine_set_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    set_reply_checker checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .mismatch_total   (mismatch_total),
        .outstanding      (outstanding),
        .requests_checked (requests_checked),
        .results_checked  (results_checked),
        .longest_reply    (longest_reply)
    );

    // Clock with a period of two time units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The consumer alternates open stretches, some of them long, with stalls.
    always @(posedge clk)
    begin
        if (open_run > 0)
        begin
            open_run--;
            rsp_ready <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            open_run  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 30);
            stall_run = $urandom_range(1, 20);
            rsp_ready <= 1'b1;
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles, %0d replies owed.",
                     QUIET_LIMIT, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // Send one request. Requests go out in bursts; between bursts the valid
    // line drops for a random gap, or stays up when the gap is zero.
    task automatic issue(input logic [2:0] op, input logic [5:0] lo,
                         input logic [5:0] hi, input logic [6:0] cnt);
        msa_req_t item;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 140);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        item.operation  = op;
        item.range_low  = lo;
        item.range_high = hi;
        item.count      = cnt;
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        burst_left--;
        issued++;
    endtask

    // One request of any kind, mostly narrow ranges and small counts.
    task automatic random_request();
        int         pick;
        int         width;
        logic [2:0] op;
        logic [5:0] lo;
        logic [5:0] hi;
        logic [6:0] cnt;
        pick  = $urandom_range(0, 99);
        lo    = 6'($urandom_range(0, 63));
        width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, 7);
        hi    = (lo + width > 63) ? 6'd63 : 6'(lo + width);
        if ($urandom_range(0, 9) == 0)
            hi = 6'($urandom_range(0, 63));
        cnt   = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 24));
        if (pick < 26)
            op = OP_INSERT;
        else if (pick < 44)
            op = OP_REMOVE;
        else if (pick < 64)
            op = OP_TAKE;
        else if (pick < 74)
            op = OP_BIGGEST;
        else if (pick < 84)
            op = OP_CONTAINS;
        else if (pick < 96)
            op = OP_INDEX;
        else if (pick < 98)
            op = OP_SPARE_LOW;
        else
            op = OP_SPARE_HIGH;
        issue(op, lo, hi, cnt);
    endtask

    // Build a comb of isolated members, then query it so that take-first
    // has to report many separate intervals.
    task automatic comb_sequence();
        int parity;
        int teeth;
        int k;
        parity = $urandom_range(0, 1);
        teeth  = $urandom_range(8, 32);
        issue(OP_REMOVE, 6'd0, 6'd63, 7'd0);
        for (k = 0; k < teeth; k++)
            issue(OP_INSERT, 6'(2 * k + parity), 6'(2 * k + parity), 7'd0);
        issue(OP_TAKE, 6'd0, 6'd0,
              ($urandom_range(0, 1) == 0) ? 7'(teeth) : 7'($urandom_range(1, teeth)));
        issue(OP_BIGGEST, 6'd0, 6'd0, 7'd0);
        issue(OP_INDEX, 6'd0, 6'd0, 7'($urandom_range(0, teeth)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Queries on the empty set.
        issue(OP_BIGGEST,  6'd0,  6'd0,  7'd0);
        issue(OP_TAKE,     6'd0,  6'd0,  7'd0);
        issue(OP_TAKE,     6'd0,  6'd0,  7'd1);
        issue(OP_INDEX,    6'd0,  6'd0,  7'd0);
        issue(OP_CONTAINS, 6'd0,  6'd0,  7'd0);
        // An inverted range changes nothing; then fill every ID.
        issue(OP_INSERT,   6'd63, 6'd0,  7'd0);
        issue(OP_INSERT,   6'd0,  6'd63, 7'd0);
        issue(OP_TAKE,     6'd0,  6'd0,  7'd64);
        issue(OP_INDEX,    6'd0,  6'd0,  7'd63);
        issue(OP_INDEX,    6'd0,  6'd0,  7'd64);
        issue(OP_TAKE,     6'd0,  6'd0,  7'd127);
        // Punch holes and look at the runs that remain.
        issue(OP_REMOVE,   6'd10, 6'd20, 7'd0);
        issue(OP_REMOVE,   6'd40, 6'd40, 7'd0);
        issue(OP_REMOVE,   6'd5,  6'd2,  7'd0);
        issue(OP_TAKE,     6'd0,  6'd0,  7'd45);
        issue(OP_BIGGEST,  6'd0,  6'd0,  7'd0);
        issue(OP_CONTAINS, 6'd10, 6'd0,  7'd0);
        issue(OP_CONTAINS, 6'd9,  6'd0,  7'd0);
        issue(OP_CONTAINS, 6'd63, 6'd63, 7'd0);
        issue(OP_INDEX,    6'd0,  6'd0,  7'd10);
        // Unused codes only report the size.
        issue(OP_SPARE_LOW,  6'd63, 6'd63, 7'd127);
        issue(OP_SPARE_HIGH, 6'd21, 6'd42, 7'd85);
        // Empty the set again.
        issue(OP_REMOVE,   6'd0,  6'd63, 7'd0);
        issue(OP_BIGGEST,  6'd0,  6'd0,  7'd0);

        // Random traffic with an occasional comb build.
        while (issued < DIRECTED_REQUESTS + RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 49) == 0)
                comb_sequence();
            else
                random_request();
        end
        req_valid <= 1'b0;

        // Let every owed reply arrive, then watch for strays.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d requests and %0d replies; the longest reply had %0d parts.",
                 requests_checked, results_checked, longest_reply);
        if (mismatch_total == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
